// ===== design/kmp_pkg.sv =====
// shared types and codes for the streaming kmp matcher
package kmp_pkg;

  localparam int unsigned MaxPatternDef = 256;

  localparam int unsigned SymbolW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CountW = 32;
  localparam int unsigned OutDataW = 40;

  localparam logic [KindW-1:0] KindClear   = 2'd0;
  localparam logic [KindW-1:0] KindAppend  = 2'd1;
  localparam logic [KindW-1:0] KindText    = 2'd2;
  localparam logic [KindW-1:0] KindRestart = 2'd3;

  typedef enum logic [3:0] {
    DpNop,
    DpClear,
    DpAppend,
    DpRestart,
    DpTextLoad,
    DpBuildInit,
    DpBuildRead,
    DpBuildStep,
    DpBuildWrite,
    DpTextRead,
    DpTextStep,
    DpTailRead,
    DpTailSet
  } dp_op_e;

  typedef struct packed {
    logic table_valid;
    logic pattern_empty;
    logic build_inner;
    logic build_more;
    logic text_exit;
    logic text_hit;
  } dp_stat_t;

endpackage

// ===== design/kmp_datapath.sv =====
// kmp datapath: pattern and failure memories, scan position and counters
module kmp_datapath #(
  parameter int unsigned MaxPattern = kmp_pkg::MaxPatternDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kmp_pkg::dp_op_e             op_i,
  input  logic [kmp_pkg::SymbolW-1:0] symbol_i,
  output kmp_pkg::dp_stat_t           stat_o,
  output logic                        hit_o,
  output logic [kmp_pkg::CountW-1:0]  count_o,
  output logic                        overflow_o
);
  import kmp_pkg::*;

  localparam int unsigned LenW  = $clog2(MaxPattern + 1);
  localparam int unsigned PosW  = LenW + 1;
  localparam int unsigned AddrW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  typedef logic signed [PosW-1:0] pos_t;

  localparam pos_t NoPos = '1;

  logic [SymbolW-1:0] pat_mem  [MaxPattern];
  pos_t               fail_mem [MaxPattern+1];

  logic [LenW-1:0]   len_q;
  logic              tvalid_q;
  pos_t              pos_q;
  logic [CountW-1:0] count_q;
  logic              ovf_q;
  logic              hit_q;

  logic [SymbolW-1:0] sym_q;
  pos_t               tj_q;
  logic [LenW-1:0]    bi_q;
  pos_t               bj_q;

  logic [SymbolW-1:0] pa_rd_q;
  logic [SymbolW-1:0] pb_rd_q;
  pos_t               f_rd_q;

  pos_t             len_s;
  pos_t             bi_s;
  pos_t             ja;
  pos_t             tj_next;
  logic [AddrW-1:0] pa_addr;
  logic [AddrW-1:0] pb_addr;
  logic [LenW-1:0]  f_addr;
  logic             rd_en;
  logic             full;
  logic             same;
  logic             build_inner;
  logic             build_more;
  logic             text_exit;
  logic             text_hit;
  logic             fw_en;
  logic [LenW-1:0]  fw_addr;
  pos_t             fw_data;

  assign len_s   = pos_t'({1'b0, len_q});
  assign bi_s    = pos_t'({1'b0, bi_q});
  assign full    = (len_q == LenW'(MaxPattern));
  assign ja      = (op_i == DpTextRead) ? tj_q : bj_q;
  assign pa_addr = ja[AddrW-1:0];
  assign pb_addr = bi_q[AddrW-1:0];
  assign f_addr  = (op_i == DpTailRead) ? len_q : ja[LenW-1:0];
  assign rd_en   = (op_i == DpBuildRead) || (op_i == DpTextRead) || (op_i == DpTailRead);

  // both positions real pattern bytes and equal
  assign same = !bj_q[PosW-1] && (bj_q < len_s) && (bi_s < len_s) && (pa_rd_q == pb_rd_q);
  assign build_inner = (bj_q != NoPos) && !same;
  assign build_more  = (bi_q < len_q);

  assign tj_next   = tj_q + pos_t'(1);
  assign text_exit = (tj_q == NoPos) || ((tj_q < len_s) && (pa_rd_q == sym_q));
  assign text_hit  = (tj_next >= len_s);

  assign fw_en   = (op_i == DpBuildInit) || (op_i == DpBuildWrite);
  assign fw_addr = (op_i == DpBuildInit) ? '0 : bi_q;
  assign fw_data = (op_i == DpBuildInit) ? NoPos : (same ? f_rd_q : bj_q);

  always_ff @(posedge clk_i) begin
    if (op_i == DpAppend && !full) begin
      pat_mem[len_q[AddrW-1:0]] <= symbol_i;
    end
    if (rd_en) begin
      pa_rd_q <= pat_mem[pa_addr];
      pb_rd_q <= pat_mem[pb_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) begin
      fail_mem[fw_addr] <= fw_data;
    end
    if (rd_en) begin
      f_rd_q <= fail_mem[f_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      tvalid_q <= 1'b0;
      pos_q    <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      unique case (op_i)
        DpClear: begin
          len_q    <= '0;
          tvalid_q <= 1'b0;
          pos_q    <= '0;
          ovf_q    <= 1'b0;
          hit_q    <= 1'b0;
        end
        DpAppend: begin
          hit_q <= 1'b0;
          if (full) begin
            ovf_q <= 1'b1;
          end else begin
            len_q    <= len_q + LenW'(1);
            tvalid_q <= 1'b0;
            pos_q    <= '0;
          end
        end
        DpRestart: begin
          hit_q   <= 1'b0;
          pos_q   <= '0;
          count_q <= '0;
        end
        DpTextLoad: begin
          hit_q <= 1'b0;
        end
        DpBuildInit: begin
          if (len_q == '0) begin
            tvalid_q <= 1'b1;
          end
        end
        DpBuildWrite: begin
          if (!build_more) begin
            tvalid_q <= 1'b1;
          end
        end
        DpTextStep: begin
          if (text_exit) begin
            if (text_hit) begin
              hit_q <= 1'b1;
              if (count_q != '1) begin
                count_q <= count_q + CountW'(1);
              end
            end else begin
              pos_q <= tj_next;
            end
          end
        end
        DpTailSet: begin
          pos_q <= f_rd_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      DpTextLoad: begin
        sym_q <= symbol_i;
        tj_q  <= pos_q;
      end
      DpBuildInit: begin
        bi_q <= '0;
        bj_q <= NoPos;
      end
      DpBuildStep: begin
        if (build_inner) begin
          bj_q <= f_rd_q;
        end else begin
          bi_q <= bi_q + LenW'(1);
          bj_q <= bj_q + pos_t'(1);
        end
      end
      DpTextStep: begin
        if (!text_exit) begin
          tj_q <= f_rd_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.table_valid   = tvalid_q;
  assign stat_o.pattern_empty = (len_q == '0);
  assign stat_o.build_inner   = build_inner;
  assign stat_o.build_more    = build_more;
  assign stat_o.text_exit     = text_exit;
  assign stat_o.text_hit      = text_hit;

  assign hit_o      = hit_q;
  assign count_o    = count_q;
  assign overflow_o = ovf_q;

endmodule

// ===== design/kmp_ctrl.sv =====
// kmp controller: sequences table build and failure-link walk
module kmp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic [kmp_pkg::KindW-1:0] kind_i,
  output logic                      s_ready_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  input  kmp_pkg::dp_stat_t         stat_i,
  output kmp_pkg::dp_op_e           op_o
);
  import kmp_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StBuildInit,
    StBuildRead,
    StBuildCmp,
    StBuildRead2,
    StBuildWrite,
    StTextRead,
    StTextCmp,
    StTailRead,
    StTailSet
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   m_valid_d;
  logic   accept;

  assign s_ready_o = (state_q == StIdle) && (!m_valid_q || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = m_valid_q;

  assign m_valid_d = (accept && (kind_i != KindText))
                  || ((state_q == StTextCmp) && stat_i.text_exit && !stat_i.text_hit)
                  || (state_q == StTailSet)
                  || (m_valid_q && !m_ready_i);

  always_comb begin
    op_o = DpNop;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (kind_i)
            KindClear:   op_o = DpClear;
            KindAppend:  op_o = DpAppend;
            KindText:    op_o = DpTextLoad;
            KindRestart: op_o = DpRestart;
          endcase
        end
      end
      StBuildInit:  op_o = DpBuildInit;
      StBuildRead:  op_o = DpBuildRead;
      StBuildCmp:   op_o = DpBuildStep;
      StBuildRead2: op_o = DpBuildRead;
      StBuildWrite: op_o = DpBuildWrite;
      StTextRead:   op_o = DpTextRead;
      StTextCmp:    op_o = DpTextStep;
      StTailRead:   op_o = DpTailRead;
      StTailSet:    op_o = DpTailSet;
      default:      op_o = DpNop;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            if (kind_i == KindText) begin
              state_q <= stat_i.table_valid ? StTextRead : StBuildInit;
            end
          end
        end
        StBuildInit: begin
          state_q <= stat_i.pattern_empty ? StTextRead : StBuildRead;
        end
        StBuildRead: begin
          state_q <= StBuildCmp;
        end
        StBuildCmp: begin
          state_q <= stat_i.build_inner ? StBuildRead : StBuildRead2;
        end
        StBuildRead2: begin
          state_q <= StBuildWrite;
        end
        StBuildWrite: begin
          state_q <= stat_i.build_more ? StBuildCmp : StTextRead;
        end
        StTextRead: begin
          state_q <= StTextCmp;
        end
        StTextCmp: begin
          if (!stat_i.text_exit) begin
            state_q <= StTextRead;
          end else if (stat_i.text_hit) begin
            state_q <= StTailRead;
          end else begin
            state_q <= StIdle;
          end
        end
        StTailRead: begin
          state_q <= StTailSet;
        end
        StTailSet: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== design/kmp_stream_matcher.sv =====
// top level of the streaming kmp matcher
//
//   channel | direction | tdata                               | tuser
//   s_axis  | in        | symbol                              | kind
//   m_axis  | out       | match_here, match_count, any, ovfl  | -
//
// clear, append and restart finish in the accept cycle
// a text byte walks the failure links with StTextRead and StTextCmp for each comparison,
// then StTailRead and StTailSet reload the tail link when a match ends at it
// the first text byte after a pattern change builds the failure table: StBuildInit, then
// StBuildCmp, StBuildRead2 and StBuildWrite per byte, StBuildRead per fallback step
// reset clears length, flags, position and count; memories need no clearing
// a new transaction is taken only when idle and the result register is free
module kmp_stream_matcher #(
  parameter int unsigned MaxPattern = kmp_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [kmp_pkg::SymbolW-1:0]   s_axis_tdata_i,   // symbol
  input  logic [kmp_pkg::KindW-1:0]     s_axis_tuser_i,   // kind
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // match_here, match_count[31:0], any_match, pattern_overflow, zero fill
  output logic [kmp_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import kmp_pkg::*;

  dp_op_e            op;
  dp_stat_t          stat;
  logic              hit;
  logic [CountW-1:0] count;
  logic              ovf;

  kmp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .kind_i    (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .op_o      (op)
  );

  kmp_datapath #(
    .MaxPattern (MaxPattern)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .symbol_i   (s_axis_tdata_i),
    .stat_o     (stat),
    .hit_o      (hit),
    .count_o    (count),
    .overflow_o (ovf)
  );

  assign m_axis_tdata_o = {5'b0, ovf, (count != '0), count, hit};

`ifndef SYNTHESIS
  a_ready_needs_free_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input taken while result is stalled");

  a_any_tracks_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[33] == (m_axis_tdata_o[32:1] != '0)))
    else $error("any_match disagrees with match_count");

  a_hit_has_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> m_axis_tdata_o[33])
    else $error("match reported with zero count");
`endif

endmodule
